/* src/bcmm_pkg.sv */
package bcmm_pkg;

    // default RAM address width
    localparam int BCMM_ADDR_BITS = 16;

    // number of general registers and the read index of the pc
    localparam int          NUM_REGS   = 8;
    localparam logic [15:0] REG_PC_IDX = 16'd8;

    // item operations
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_EXEC = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    // instruction opcodes
    localparam logic [7:0] OPC_MOV_RR  = 8'd0;
    localparam logic [7:0] OPC_IMM_REG = 8'd1;
    localparam logic [7:0] OPC_MEM_REG = 8'd2;
    localparam logic [7:0] OPC_REG_MEM = 8'd3;
    localparam logic [7:0] OPC_IMM_MEM = 8'd4;
    localparam logic [7:0] OPC_HALT    = 8'd5;

    // input beat
    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] address;
        logic [7:0]  data_byte;
    } t_in;

    // result beat
    typedef struct packed {
        logic        halted;
        logic        bad_opcode;
        logic [15:0] register_read;
        logic [15:0] pc_after;
        logic        reg_written;
        logic [2:0]  reg_index;
        logic [15:0] reg_value;
        logic        mem_written;
        logic [15:0] mem_address;
        logic [15:0] mem_value;
        logic        mem_byte_only;
    } t_out;

endpackage

/* src/byte_coded_move_machine_step.sv */
// execute beats take one state per ram byte access (up to six reads, two writes), one to take
// the last byte read and one to post the result; load, read, no-op and halted execute beats
// go straight to posting, and posting waits while the output register stays stalled
// beats are handled one at a time; the next beat is taken once the previous result is posted
// reset: registers, pc and halt flag clear at once, then the ram is zeroed one byte per cycle
// across all 2**ADDR_BITS addresses with the input stalled
module byte_coded_move_machine_step
    import bcmm_pkg::*;
#(
    parameter int ADDR_BITS = BCMM_ADDR_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_OPC, S_B, S_IMLO, S_IMHI, S_EALO, S_EAHI,
        S_MLO, S_MHI, S_WR0, S_WR1, S_DONE
    } t_state;

    t_state                r_state;
    logic [ADDR_BITS-1:0]  r_clr;
    logic [15:0]           r_pc;
    logic                  r_halt;
    logic [15:0]           r_rf [NUM_REGS];
    logic [7:0]            r_opc;
    logic [7:0]            r_b;
    logic                  r_sz;
    logic [7:0]            r_ea_lo;
    logic [ADDR_BITS-1:0]  r_ea;
    logic [15:0]           r_v;
    t_out                  r_res;
    t_out                  r_out;
    t_out                  n_out;
    logic                  r_out_valid;

    logic [7:0]            r_mem [2**ADDR_BITS];
    logic [7:0]            r_mem_q;

    logic                  in_accept;
    logic [15:0]           ea_full;
    logic                  mem_we;
    logic [ADDR_BITS-1:0]  mem_addr;
    logic [7:0]            mem_wdata;
    logic                  rf_we;
    logic [2:0]            rf_idx;
    logic [15:0]           rf_val;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign ea_full     = {r_mem_q, r_ea_lo};

    // ram port: clearing, loads, fetches at the pc, operand reads and stores
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_pc[ADDR_BITS-1:0];
        mem_wdata = r_v[7:0];
        case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_addr  = r_clr;
                mem_wdata = 8'h00;
            end
            S_IDLE: begin
                if (in_accept && i_in.operation == OP_LOAD) begin
                    mem_we    = 1'b1;
                    mem_addr  = i_in.address[ADDR_BITS-1:0];
                    mem_wdata = i_in.data_byte;
                end
            end
            S_EAHI: begin
                // only a memory-to-register move reads its operand here,
                // an immediate-to-memory move keeps fetching at the pc
                if (r_opc == OPC_MEM_REG) begin
                    mem_addr = ea_full[ADDR_BITS-1:0];
                end
            end
            S_MLO:  mem_addr = r_ea + 1'b1;
            S_WR0: begin
                mem_we   = 1'b1;
                mem_addr = r_ea;
            end
            S_WR1: begin
                mem_we    = 1'b1;
                mem_addr  = r_ea + 1'b1;
                mem_wdata = r_v[15:8];
            end
            default: ;
        endcase
    end

    // single-port ram with registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_mem_q <= r_mem[mem_addr];
    end

    // register write-back, byte moves zero-extend
    always_comb begin
        rf_we  = 1'b0;
        rf_idx = r_b[2:0];
        rf_val = r_v;
        case (r_state)
            S_B: begin
                if (r_opc == OPC_MOV_RR) begin
                    rf_we  = 1'b1;
                    rf_idx = r_mem_q[2:0];
                    rf_val = r_rf[r_mem_q[5:3]];
                    if (r_mem_q[6]) begin
                        rf_val[15:8] = 8'h00;
                    end
                end
            end
            S_IMLO: begin
                rf_we  = (r_opc == OPC_IMM_REG) && r_sz;
                rf_val = {8'h00, r_mem_q};
            end
            S_IMHI: begin
                rf_we  = (r_opc == OPC_IMM_REG);
                rf_val = {r_mem_q, r_v[7:0]};
            end
            S_MLO: begin
                rf_we  = r_sz;
                rf_val = {8'h00, r_mem_q};
            end
            S_MHI: begin
                rf_we  = 1'b1;
                rf_val = {r_mem_q, r_v[7:0]};
            end
            default: ;
        endcase
    end

    // result beat with the final halt flag and pc
    always_comb begin
        n_out          = r_res;
        n_out.halted   = r_halt;
        n_out.pc_after = r_pc;
    end

    // instruction sequencer, one ram byte per state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_pc        <= '0;
            r_halt      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_REGS; k++) begin
                r_rf[k] <= '0;
            end
        end else begin
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            if (rf_we) begin
                r_rf[rf_idx]      <= rf_val;
                r_res.reg_written <= 1'b1;
                r_res.reg_index   <= rf_idx;
                r_res.reg_value   <= rf_val;
            end
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (&r_clr) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_accept) begin
                        r_res   <= '0;
                        r_state <= S_DONE;
                        case (i_in.operation)
                            OP_READ: begin
                                if (i_in.address < 16'(NUM_REGS)) begin
                                    r_res.register_read <= r_rf[i_in.address[2:0]];
                                end else if (i_in.address == REG_PC_IDX) begin
                                    r_res.register_read <= r_pc;
                                end
                            end
                            OP_EXEC: begin
                                if (!r_halt) begin
                                    r_pc    <= r_pc + 16'd1;
                                    r_state <= S_OPC;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_OPC: begin
                    r_opc <= r_mem_q;
                    if (r_mem_q == OPC_HALT) begin
                        r_halt  <= 1'b1;
                        r_state <= S_DONE;
                    end else if (r_mem_q > OPC_HALT) begin
                        r_res.bad_opcode <= 1'b1;
                        r_state          <= S_DONE;
                    end else begin
                        r_pc    <= r_pc + 16'd1;
                        r_state <= S_B;
                    end
                end
                S_B: begin
                    r_b <= r_mem_q;
                    case (r_opc)
                        OPC_MOV_RR:  r_sz <= r_mem_q[6];
                        OPC_IMM_MEM: r_sz <= r_mem_q[0];
                        default:     r_sz <= r_mem_q[3];
                    endcase
                    if (r_opc == OPC_MOV_RR) begin
                        r_state <= S_DONE;
                    end else begin
                        r_pc    <= r_pc + 16'd1;
                        r_state <= (r_opc == OPC_IMM_REG) ? S_IMLO : S_EALO;
                    end
                end
                S_IMLO: begin
                    r_v <= {8'h00, r_mem_q};
                    if (r_sz) begin
                        r_state <= (r_opc == OPC_IMM_MEM) ? S_WR0 : S_DONE;
                    end else begin
                        r_pc    <= r_pc + 16'd1;
                        r_state <= S_IMHI;
                    end
                end
                S_IMHI: begin
                    r_v[15:8] <= r_mem_q;
                    r_state   <= (r_opc == OPC_IMM_MEM) ? S_WR0 : S_DONE;
                end
                S_EALO: begin
                    r_ea_lo <= r_mem_q;
                    r_pc    <= r_pc + 16'd1;
                    r_state <= S_EAHI;
                end
                S_EAHI: begin
                    r_ea <= ea_full[ADDR_BITS-1:0];
                    case (r_opc)
                        OPC_MEM_REG: r_state <= S_MLO;
                        OPC_REG_MEM: begin
                            r_v     <= r_rf[r_b[2:0]];
                            r_state <= S_WR0;
                        end
                        default: begin
                            r_pc    <= r_pc + 16'd1;
                            r_state <= S_IMLO;
                        end
                    endcase
                end
                S_MLO: begin
                    r_v     <= {8'h00, r_mem_q};
                    r_state <= r_sz ? S_DONE : S_MHI;
                end
                S_MHI: r_state <= S_DONE;
                S_WR0: begin
                    r_res.mem_written   <= 1'b1;
                    r_res.mem_address   <= 16'(r_ea);
                    r_res.mem_value     <= r_sz ? {8'h00, r_v[7:0]} : r_v;
                    r_res.mem_byte_only <= r_sz;
                    r_state             <= r_sz ? S_DONE : S_WR1;
                end
                S_WR1: r_state <= S_DONE;
                S_DONE: begin
                    // post the result beat once the output register is free
                    if (!r_out_valid || !i_out_stall) begin
                        r_out       <= n_out;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ram writes only while clearing, loading or storing
    a_mem_we_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_CLR || r_state == S_IDLE || r_state == S_WR0 ||
                    r_state == S_WR1))
        else $error("ram write outside clear, load or store");

    // halt is sticky until reset
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt flag dropped");

    // execute while halted completes without touching the pc
    a_halted_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in.operation == OP_EXEC && r_halt) |=>
            (r_state == S_DONE && $stable(r_pc)))
        else $error("halted execute did not skip");

    // one instruction never both stores and writes a register
    a_one_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.mem_written && r_out.reg_written))
        else $error("result reports both a store and a register write");

endmodule

/* dv/tb_byte_coded_move_machine_step.sv */
module tb_byte_coded_move_machine_step;
    import bcmm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_BITS    = BCMM_ADDR_BITS;
    localparam int MEM_SIZE     = 1 << ADDR_BITS;
    localparam int MEM_MASK     = MEM_SIZE - 1;
    localparam int CLK_PERIOD   = 12;
    localparam int IDLE_PCT     = 38;
    localparam int RANDOM_BEATS = 600;
    localparam int QUIET_BEATS  = 60;
    localparam int DRAIN_CYCLES = 16;
    localparam int REPORT_MAX   = 10;
    localparam int TIMEOUT_NS   = 20_000_000;

    // the fourth operation code does nothing
    localparam logic [1:0] OP_NONE = 2'd3;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in        = '0;
    logic i_out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out;

    // machine image kept by the predictor
    logic [7:0]  ram_img [0:MEM_SIZE-1];
    logic [15:0] gpr_img [0:NUM_REGS-1];
    logic [15:0] pc_img;
    logic        halt_img;

    t_out pending_results [$];
    int   mismatch_count = 0;
    int   result_count   = 0;
    int   beats_sent     = 0;
    bit   quiet          = 1'b0;

    byte_coded_move_machine_step #(
        .ADDR_BITS(ADDR_BITS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // predictor: ram access and instruction fetch
    function automatic logic [7:0] ram_rd(input logic [15:0] a);
        return ram_img[a & MEM_MASK];
    endfunction

    function automatic logic [7:0] fetch_byte();
        logic [7:0] v;
        v = ram_rd(pc_img);
        pc_img = pc_img + 16'd1;
        return v;
    endfunction

    function automatic logic [15:0] fetch_word();
        logic [7:0] lo, hi;
        lo = fetch_byte();
        hi = fetch_byte();
        return {hi, lo};
    endfunction

    // predictor: one accepted beat in, one result out
    function automatic t_out step_machine(input t_in beat);
        t_out        res;
        logic [7:0]  opc, b;
        logic [15:0] ea, v;
        logic        sz;
        res = '0;
        case (beat.operation)
            OP_LOAD: ram_img[beat.address & MEM_MASK] = beat.data_byte;
            OP_READ: begin
                if (beat.address < NUM_REGS)
                    res.register_read = gpr_img[beat.address[2:0]];
                else if (beat.address == REG_PC_IDX)
                    res.register_read = pc_img;
            end
            OP_EXEC: begin
                if (!halt_img) begin
                    opc = fetch_byte();
                    case (opc)
                        OPC_MOV_RR: begin
                            b = fetch_byte();
                            v = gpr_img[b[5:3]];
                            if (b[6]) v[15:8] = '0;
                            res.reg_written = 1'b1;
                            res.reg_index   = b[2:0];
                            res.reg_value   = v;
                        end
                        OPC_IMM_REG: begin
                            b = fetch_byte();
                            if (b[3]) v = {8'h00, fetch_byte()};
                            else v = fetch_word();
                            res.reg_written = 1'b1;
                            res.reg_index   = b[2:0];
                            res.reg_value   = v;
                        end
                        OPC_MEM_REG: begin
                            b  = fetch_byte();
                            ea = fetch_word();
                            if (b[3]) v = {8'h00, ram_rd(ea)};
                            else v = {ram_rd(ea + 16'd1), ram_rd(ea)};
                            res.reg_written = 1'b1;
                            res.reg_index   = b[2:0];
                            res.reg_value   = v;
                        end
                        OPC_REG_MEM, OPC_IMM_MEM: begin
                            b = fetch_byte();
                            if (opc == OPC_REG_MEM) begin
                                sz = b[3];
                                ea = fetch_word();
                                v  = gpr_img[b[2:0]];
                            end else begin
                                sz = b[0];
                                ea = fetch_word();
                                // immediate is fetched before the store lands
                                if (sz) v = {8'h00, fetch_byte()};
                                else v = fetch_word();
                            end
                            ea = 16'(ea & MEM_MASK);
                            ram_img[ea] = v[7:0];
                            if (sz) v[15:8] = '0;
                            else ram_img[(ea + 1) & MEM_MASK] = v[15:8];
                            res.mem_written   = 1'b1;
                            res.mem_address   = ea;
                            res.mem_value     = v;
                            res.mem_byte_only = sz;
                        end
                        OPC_HALT: halt_img = 1'b1;
                        default: res.bad_opcode = 1'b1;
                    endcase
                    if (res.reg_written) gpr_img[res.reg_index] = res.reg_value;
                end
            end
            default: ;
        endcase
        res.halted   = halt_img;
        res.pc_after = pc_img;
        return res;
    endfunction

    // send one beat, with a random gap first unless quiet
    task automatic send_beat(input t_in beat);
        if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            do @(negedge i_clk);
            while (!quiet && $urandom_range(0, 99) < IDLE_PCT);
        end
        i_in_valid <= 1'b1;
        i_in       <= beat;
        do @(posedge i_clk);
        while (o_in_stall);
        pending_results.push_back(step_machine(beat));
        if (beat.operation != OP_NONE) beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic load_byte(input logic [15:0] addr, input logic [7:0] data);
        send_beat(t_in'{OP_LOAD, addr, data});
    endtask

    task automatic read_reg(input logic [15:0] idx);
        send_beat(t_in'{OP_READ, idx, 8'($urandom)});
    endtask

    task automatic exec_step();
        send_beat(t_in'{OP_EXEC, 16'($urandom), 8'($urandom)});
    endtask

    task automatic send_noop();
        send_beat(t_in'{OP_NONE, 16'($urandom), 8'($urandom)});
    endtask

    // place an instruction at the pc and run it
    task automatic run_code(input logic [7:0] code [6], input int len);
        for (int k = 0; k < len; k++)
            load_byte(16'(pc_img + k), code[k]);
        exec_step();
    endtask

    // run whatever sits at the pc, but never let a halt through
    task automatic exec_at_pc();
        if (ram_img[pc_img & MEM_MASK] == OPC_HALT)
            load_byte(pc_img, 8'($urandom_range(6, 255)));
        exec_step();
    endtask

    // hold the sender until every result is back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // data window, top of ram, just past the pc, or anywhere
    function automatic logic [15:0] pick_address();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 16'h4000 + 16'($urandom_range(0, 15));
            5:             return 16'hFFFF;
            6:             return 16'(pc_img + $urandom_range(2, 7));
            default:       return 16'($urandom);
        endcase
    endfunction

    task automatic random_instruction();
        logic [7:0]  code [6];
        logic [15:0] ea;
        int          len;
        for (int k = 0; k < 6; k++) code[k] = 8'($urandom);
        ea = pick_address();
        case ($urandom_range(0, 5))
            0: begin
                code[0] = OPC_MOV_RR;
                len = 2;
            end
            1: begin
                code[0] = OPC_IMM_REG;
                len = code[1][3] ? 3 : 4;
            end
            2: begin
                code[0] = OPC_MEM_REG;
                code[2] = ea[7:0];
                code[3] = ea[15:8];
                len = 4;
            end
            3: begin
                code[0] = OPC_REG_MEM;
                code[2] = ea[7:0];
                code[3] = ea[15:8];
                len = 4;
            end
            4: begin
                code[0] = OPC_IMM_MEM;
                code[2] = ea[7:0];
                code[3] = ea[15:8];
                len = code[1][0] ? 5 : 6;
            end
            default: begin
                code[0] = 8'($urandom_range(6, 255));
                len = 1;
            end
        endcase
        run_code(code, len);
    endtask

    // register reads at the index edges and a no-op beat
    task automatic test_reads_and_noop();
        read_reg(REG_PC_IDX);
        read_reg(16'hFFFF);
        send_beat(t_in'{OP_NONE, 16'hFFFF, 8'hFF});
    endtask

    // one of each move kind, with wrap at the top of ram
    task automatic test_moves();
        logic [15:0] ea;
        // r7 = ffff from a word immediate
        run_code('{OPC_IMM_REG, 8'h07, 8'hFF, 8'hFF, 8'h00, 8'h00}, 4);
        // r0 = low byte of r7, zero-extended
        run_code('{OPC_MOV_RR, 8'h78, 8'h00, 8'h00, 8'h00, 8'h00}, 2);
        // word store at the last address wraps to zero
        run_code('{OPC_REG_MEM, 8'h07, 8'hFF, 8'hFF, 8'h00, 8'h00}, 4);
        // word read across the same wrap
        run_code('{OPC_MEM_REG, 8'h01, 8'hFF, 8'hFF, 8'h00, 8'h00}, 4);
        // word store over its own immediate
        ea = pc_img + 16'd4;
        run_code('{OPC_IMM_MEM, 8'h00, ea[7:0], ea[15:8], 8'hCD, 8'hAB}, 6);
    endtask

    // unknown opcodes at both ends of the range
    task automatic test_bad_opcode();
        run_code('{8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1);
        run_code('{8'h06, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1);
    endtask

    // mostly well-formed instructions, with reads, stray loads and no-ops
    task automatic test_random_programs(input int count);
        int stop_at;
        int pick;
        stop_at = beats_sent + count;
        while (beats_sent < stop_at) begin
            pick = $urandom_range(0, 19);
            if (pick < 12)
                random_instruction();
            else if (pick < 14)
                read_reg(($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, 8)));
            else if (pick < 16)
                load_byte(16'($urandom), 8'($urandom));
            else if (pick < 17)
                send_noop();
            else
                exec_at_pc();
        end
    endtask

    // a long stretch with no idling on either side
    task automatic test_no_idle(input int count);
        quiet = 1'b1;
        test_random_programs(count);
        quiet = 1'b0;
    endtask

    // halt, then steps do nothing while loads and reads still work
    task automatic test_halt();
        wait_drained();
        run_code('{OPC_HALT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1);
        exec_step();
        exec_step();
        load_byte(16'($urandom), 8'($urandom));
        read_reg(REG_PC_IDX);
        read_reg(16'd5);
        send_noop();
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
                $display("result %0d %s: expected 0x%0h, actual 0x%0h",
                         result_count, name, want, got);
        end
    endtask

    // receiver stalls at random unless quiet
    always @(negedge i_clk)
        i_out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);

    // compare each result beat with the oldest prediction
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("result %0d arrived with nothing predicted", result_count);
            end else begin
                want = pending_results.pop_front();
                check_field("halted",        want.halted,        o_out.halted);
                check_field("bad_opcode",    want.bad_opcode,    o_out.bad_opcode);
                check_field("register_read", want.register_read, o_out.register_read);
                check_field("pc_after",      want.pc_after,      o_out.pc_after);
                check_field("reg_written",   want.reg_written,   o_out.reg_written);
                check_field("reg_index",     want.reg_index,     o_out.reg_index);
                check_field("reg_value",     want.reg_value,     o_out.reg_value);
                check_field("mem_written",   want.mem_written,   o_out.mem_written);
                check_field("mem_address",   want.mem_address,   o_out.mem_address);
                check_field("mem_value",     want.mem_value,     o_out.mem_value);
                check_field("mem_byte_only", want.mem_byte_only, o_out.mem_byte_only);
            end
            result_count++;
        end
    end

    // stimulus sequence
    initial begin
        for (int k = 0; k < MEM_SIZE; k++) ram_img[k] = '0;
        for (int k = 0; k < NUM_REGS; k++) gpr_img[k] = '0;
        pc_img   = '0;
        halt_img = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reads_and_noop();
        test_moves();
        test_bad_opcode();
        test_random_programs(RANDOM_BEATS);
        test_no_idle(QUIET_BEATS);
        test_halt();

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog, covers the ram clear after reset
    initial begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

/* filelist.f */
src/bcmm_pkg.sv
src/byte_coded_move_machine_step.sv
dv/tb_byte_coded_move_machine_step.sv
